// ===== design/lsmt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsmt_pkg
// Shared constants for the LCD scanline mode timing block: line timing,
// mode codes, status interrupt source bits and register indexes.
// ----------------------------------------------------------------------------
package lsmt_pkg;

   // Line timing, in clock cycles and line numbers
   localparam int unsigned CountWidth    = 10;
   localparam int unsigned LineWidth     = 8;
   localparam int unsigned ElapsedWidth  = 8;

   localparam logic [CountWidth-1:0] LINE_CYCLES  = 10'd456;
   localparam logic [CountWidth-1:0] OAM_END      = 10'd80;
   localparam logic [CountWidth-1:0] TRANSFER_END = 10'd252;
   localparam logic [LineWidth-1:0]  FIRST_VBLANK = 8'd144;
   localparam logic [LineWidth-1:0]  LAST_LINE    = 8'd153;

   // Display mode codes
   localparam logic [1:0] MODE_HBLANK   = 2'd0;
   localparam logic [1:0] MODE_VBLANK   = 2'd1;
   localparam logic [1:0] MODE_OAM      = 2'd2;
   localparam logic [1:0] MODE_TRANSFER = 2'd3;

   // Status interrupt enable bit positions
   localparam int unsigned SRC_HBLANK   = 0;
   localparam int unsigned SRC_VBLANK   = 1;
   localparam int unsigned SRC_OAM      = 2;
   localparam int unsigned SRC_COINCIDE = 3;

   // Register indexes
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 8;
   localparam logic [CsrIndexWidth-1:0] CSR_DISPLAY_ENABLE     = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_LINE_COMPARE       = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_STATUS_IRQ_ENABLES = 2'd2;

endpackage

// ===== design/lcd_scanline_mode_timing.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_scanline_mode_timing
// Line-cycle counter that steps the display through OAM scan, transfer,
// horizontal blank and vertical blank, with interrupt and render pulses.
// ----------------------------------------------------------------------------
// With the display on, each req adds elapsed_cycles to the line-cycle counter and
// yields exactly one rsp transaction with the mode, line, coincidence flag and
// the pulses caused by that step. The timing state is updated in the cycle a
// transaction is accepted, by one add and a few compares on a 10-bit counter,
// and the result lands in an output register. A new transaction is taken
// every clock, including while a finished result is being taken by the
// consumer; the only stall is an unconsumed result held in the output
// register. Configuration writes are accepted every cycle and take effect on
// the next step; an index beyond the register list is ignored.
// ----------------------------------------------------------------------------
module lcd_scanline_mode_timing (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lsmt_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [lsmt_pkg::CsrDataWidth-1:0]    csr_wdata,
   // input items
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [lsmt_pkg::ElapsedWidth-1:0]    req_elapsed_cycles,
   // results
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_current_mode,
   output logic [lsmt_pkg::LineWidth-1:0]       rsp_current_line,
   output logic                                 rsp_coincidence,
   output logic                                 rsp_vblank_irq,
   output logic                                 rsp_status_irq,
   output logic                                 rsp_render_line,
   output logic                                 rsp_frame_done
);

   // Configuration registers
   logic                               display_enable_ff;
   logic [lsmt_pkg::LineWidth-1:0]     line_compare_ff;
   logic [3:0]                         irq_enables_ff;

   // Timing state
   logic [lsmt_pkg::CountWidth-1:0]    count_ff, count_in;
   logic [lsmt_pkg::LineWidth-1:0]     line_ff, line_in;
   logic [1:0]                         mode_ff, mode_in;
   logic                               coinc_ff, coinc_in;

   // Result register
   logic                               rsp_valid_ff;
   logic [1:0]                         out_mode_ff;
   logic [lsmt_pkg::LineWidth-1:0]     out_line_ff;
   logic                               out_coinc_ff;
   logic                               out_vblank_ff, vblank_in;
   logic                               out_status_ff, status_in;
   logic                               out_render_ff, render_in;
   logic                               out_frame_ff, frame_in;

   // Step datapath
   logic                               accept;
   logic [lsmt_pkg::CountWidth-1:0]    sum;
   logic                               line_end;
   logic [lsmt_pkg::LineWidth-1:0]     line_inc;
   logic                               wrap;
   logic [lsmt_pkg::LineWidth-1:0]     line_adv;
   logic                               coinc_adv;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign sum      = count_ff + {{(lsmt_pkg::CountWidth-lsmt_pkg::ElapsedWidth){1'b0}},
                                 req_elapsed_cycles};
   assign line_end = (sum >= lsmt_pkg::LINE_CYCLES);
   assign line_inc = line_ff + 8'd1;
   assign wrap     = (line_ff >= lsmt_pkg::LAST_LINE);
   assign line_adv = wrap ? '0 : line_inc;
   assign coinc_adv = (line_adv == line_compare_ff);

   // Next timing state and pulses for one step
   always_comb begin
      count_in  = count_ff;
      line_in   = line_ff;
      mode_in   = mode_ff;
      coinc_in  = coinc_ff;
      vblank_in = 1'b0;
      status_in = 1'b0;
      render_in = 1'b0;
      frame_in  = 1'b0;
      if (!display_enable_ff) begin
         count_in = '0;
         line_in  = '0;
         mode_in  = lsmt_pkg::MODE_HBLANK;
      end else if (line_ff < lsmt_pkg::FIRST_VBLANK) begin
         // visible line
         count_in = sum;
         if (sum < lsmt_pkg::OAM_END) begin
            if (mode_ff != lsmt_pkg::MODE_OAM) begin
               mode_in   = lsmt_pkg::MODE_OAM;
               status_in = irq_enables_ff[lsmt_pkg::SRC_OAM];
            end
         end else if (sum < lsmt_pkg::TRANSFER_END) begin
            mode_in = lsmt_pkg::MODE_TRANSFER;
         end else if (!line_end) begin
            if (mode_ff != lsmt_pkg::MODE_HBLANK) begin
               mode_in   = lsmt_pkg::MODE_HBLANK;
               status_in = irq_enables_ff[lsmt_pkg::SRC_HBLANK];
               render_in = 1'b1;
            end
         end else begin
            // line never exceeds the visible range here, so no wrap
            count_in  = sum - lsmt_pkg::LINE_CYCLES;
            line_in   = line_inc;
            coinc_in  = (line_inc == line_compare_ff);
            status_in = (line_inc == line_compare_ff) &&
                        irq_enables_ff[lsmt_pkg::SRC_COINCIDE];
         end
      end else begin
         // vertical blank lines
         count_in = sum;
         if (mode_ff != lsmt_pkg::MODE_VBLANK) begin
            mode_in   = lsmt_pkg::MODE_VBLANK;
            vblank_in = 1'b1;
            status_in = irq_enables_ff[lsmt_pkg::SRC_VBLANK];
         end
         if (line_end) begin
            count_in = sum - lsmt_pkg::LINE_CYCLES;
            line_in  = line_adv;
            frame_in = wrap;
            coinc_in = coinc_adv;
            if (coinc_adv && irq_enables_ff[lsmt_pkg::SRC_COINCIDE]) begin
               status_in = 1'b1;
            end
         end
      end
   end

   // Configuration, timing state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         display_enable_ff <= 1'b1;
         line_compare_ff   <= '0;
         irq_enables_ff    <= '0;
         count_ff          <= '0;
         line_ff           <= '0;
         mode_ff           <= lsmt_pkg::MODE_VBLANK;
         coinc_ff          <= 1'b1;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               lsmt_pkg::CSR_DISPLAY_ENABLE:     display_enable_ff <= csr_wdata[0];
               lsmt_pkg::CSR_LINE_COMPARE:       line_compare_ff   <= csr_wdata;
               lsmt_pkg::CSR_STATUS_IRQ_ENABLES: irq_enables_ff    <= csr_wdata[3:0];
               default: ;
            endcase
         end
         if (accept) begin
            count_ff     <= count_in;
            line_ff      <= line_in;
            mode_ff      <= mode_in;
            coinc_ff     <= coinc_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         out_mode_ff   <= mode_in;
         out_line_ff   <= line_in;
         out_coinc_ff  <= coinc_in;
         out_vblank_ff <= vblank_in;
         out_status_ff <= status_in;
         out_render_ff <= render_in;
         out_frame_ff  <= frame_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_current_mode = out_mode_ff;
   assign rsp_current_line = out_line_ff;
   assign rsp_coincidence  = out_coinc_ff;
   assign rsp_vblank_irq   = out_vblank_ff;
   assign rsp_status_irq   = out_status_ff;
   assign rsp_render_line  = out_render_ff;
   assign rsp_frame_done   = out_frame_ff;

endmodule

// ===== dv/lcd_scanline_mode_timing_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_scanline_mode_timing_tb
// Self-checking bench for the LCD scanline mode timing block. A scoreboard
// class keeps its own copy of the line timing state and the registers,
// predicts one result per accepted elapsed-cycle transaction and compares
// every result field by field. The stimulus is a short directed walk through
// the mode changes, then phases of random traffic. Each phase uses its own
// register values and has bursty input and a stalling consumer.
// ----------------------------------------------------------------------------

import lsmt_pkg::*;

typedef struct {
   logic [1:0]           mode;
   logic [LineWidth-1:0] line;
   logic                 coincidence;
   logic                 vblank_irq;
   logic                 status_irq;
   logic                 render_line;
   logic                 frame_done;
} scan_result_t;

// Line timing predictor and store of expected results
class scanline_scoreboard;
   bit                    display_on;
   bit [LineWidth-1:0]    compare_value;
   bit [3:0]              irq_enables;
   bit [CountWidth-1:0]   cycle_count;
   bit [LineWidth-1:0]    line_no;
   bit [1:0]              mode;
   bit                    coincident;
   scan_result_t          expected_q[$];
   int unsigned           errors, checked, reg_writes;
   int unsigned           frames, vblanks, status_irqs, renders, compare_hits;

   function new();
      display_on    = 1'b1;
      compare_value = '0;
      irq_enables   = '0;
      cycle_count   = '0;
      line_no       = '0;
      mode          = MODE_VBLANK;
      coincident    = 1'b1;
   endfunction

   function int unsigned pending();
      return expected_q.size();
   endfunction

   task report(string msg);
      errors++;
      // keep the log short when something goes badly wrong
      if (errors <= 30)
         $display("[%0t] ERROR: %s", $time, msg);
   endtask

   function void write_reg(logic [CsrIndexWidth-1:0] index,
                           logic [CsrDataWidth-1:0] data);
      reg_writes++;
      case (index)
         CSR_DISPLAY_ENABLE:     display_on    = data[0];
         CSR_LINE_COMPARE:       compare_value = data[LineWidth-1:0];
         CSR_STATUS_IRQ_ENABLES: irq_enables   = data[3:0];
         default: ;
      endcase
   endfunction

   // New line: refresh the coincidence flag, return the status request it makes
   function bit line_changed();
      coincident = (line_no == compare_value);
      if (coincident)
         compare_hits++;
      return coincident && irq_enables[SRC_COINCIDE];
   endfunction

   function void note_input(logic [ElapsedWidth-1:0] elapsed);
      scan_result_t r;
      r = '{default: '0};
      if (!display_on) begin
         cycle_count = '0;
         line_no     = '0;
         mode        = MODE_HBLANK;
      end else begin
         cycle_count = cycle_count + elapsed;
         if (line_no < FIRST_VBLANK) begin
            // visible line: at most one mode change or a line advance
            if (cycle_count < OAM_END) begin
               if (mode != MODE_OAM) begin
                  mode         = MODE_OAM;
                  r.status_irq = irq_enables[SRC_OAM];
               end
            end else if (cycle_count < TRANSFER_END) begin
               mode = MODE_TRANSFER;
            end else if (cycle_count < LINE_CYCLES) begin
               if (mode != MODE_HBLANK) begin
                  mode          = MODE_HBLANK;
                  r.status_irq  = irq_enables[SRC_HBLANK];
                  r.render_line = 1'b1;
               end
            end else begin
               cycle_count  = cycle_count - LINE_CYCLES;
               line_no      = line_no + 1'b1;
               r.status_irq = line_changed();
            end
         end else begin
            // vertical blank: entry and a line advance may share one step
            if (mode != MODE_VBLANK) begin
               mode         = MODE_VBLANK;
               r.vblank_irq = 1'b1;
               r.status_irq = irq_enables[SRC_VBLANK];
            end
            if (cycle_count >= LINE_CYCLES) begin
               cycle_count = cycle_count - LINE_CYCLES;
               if (line_no == LAST_LINE) begin
                  line_no      = '0;
                  r.frame_done = 1'b1;
               end else begin
                  line_no = line_no + 1'b1;
               end
               r.status_irq = r.status_irq | line_changed();
            end
         end
      end
      r.mode        = mode;
      r.line        = line_no;
      r.coincidence = coincident;
      expected_q.push_back(r);
   endfunction

   task check_field(string name, int got_v, int exp_v);
      if (got_v != exp_v)
         report($sformatf("result %0d: %s is %0d, expected %0d",
                          checked, name, got_v, exp_v));
   endtask

   task check_result(scan_result_t got);
      scan_result_t exp;
      if (expected_q.size() == 0) begin
         report("result transaction with no input outstanding");
         return;
      end
      exp = expected_q.pop_front();
      check_field("current_mode", got.mode,        exp.mode);
      check_field("current_line", got.line,        exp.line);
      check_field("coincidence",  got.coincidence, exp.coincidence);
      check_field("vblank_irq",   got.vblank_irq,  exp.vblank_irq);
      check_field("status_irq",   got.status_irq,  exp.status_irq);
      check_field("render_line",  got.render_line, exp.render_line);
      check_field("frame_done",   got.frame_done,  exp.frame_done);
      checked++;
      frames      += exp.frame_done;
      vblanks     += exp.vblank_irq;
      status_irqs += exp.status_irq;
      renders     += exp.render_line;
   endtask
endclass

module lcd_scanline_mode_timing_tb;

   localparam logic [CsrIndexWidth-1:0] CSR_UNMAPPED = 2'd3;

   // which registers a configuration step writes
   localparam logic [3:0] SET_ENABLE   = 4'b0001;
   localparam logic [3:0] SET_COMPARE  = 4'b0010;
   localparam logic [3:0] SET_IRQ      = 4'b0100;
   localparam logic [3:0] SET_UNMAPPED = 4'b1000;

   localparam int unsigned PHASES    = 12;
   localparam int unsigned OFF_PHASE = 6;

   logic                       clock;
   logic                       reset;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CsrIndexWidth-1:0]   csr_index;
   logic [CsrDataWidth-1:0]    csr_wdata;
   logic                       req_valid;
   logic                       req_ready;
   logic [ElapsedWidth-1:0]    req_elapsed_cycles;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [1:0]                 rsp_current_mode;
   logic [LineWidth-1:0]       rsp_current_line;
   logic                       rsp_coincidence;
   logic                       rsp_vblank_irq;
   logic                       rsp_status_irq;
   logic                       rsp_render_line;
   logic                       rsp_frame_done;

   bit                         long_hold;
   scanline_scoreboard         sb;

   lcd_scanline_mode_timing DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_elapsed_cycles (req_elapsed_cycles),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_current_mode   (rsp_current_mode),
      .rsp_current_line   (rsp_current_line),
      .rsp_coincidence    (rsp_coincidence),
      .rsp_vblank_irq     (rsp_vblank_irq),
      .rsp_status_irq     (rsp_status_irq),
      .rsp_render_line    (rsp_render_line),
      .rsp_frame_done     (rsp_frame_done)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case a handshake never completes
   initial begin
      #(64'd5_000_000);
      $display("simulation failed");
      $finish;
   end

   // Transaction monitor: values read here are the ones before the edge
   always @(posedge clock) begin : monitor
      scan_result_t got;
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.write_reg(csr_index, csr_wdata);
         if (rsp_valid && rsp_ready) begin
            got.mode        = rsp_current_mode;
            got.line        = rsp_current_line;
            got.coincidence = rsp_coincidence;
            got.vblank_irq  = rsp_vblank_irq;
            got.status_irq  = rsp_status_irq;
            got.render_line = rsp_render_line;
            got.frame_done  = rsp_frame_done;
            sb.check_result(got);
         end
         if (req_valid && req_ready)
            sb.note_input(req_elapsed_cycles);
      end
   end

   // Consumer: segments of free flow, random and heavy stalls, and long holds
   initial begin : receiver
      int unsigned segment, seg_len, style;
      bit          holding;
      rsp_ready <= 1'b0;
      long_hold <= 1'b0;
      segment = 0;
      do @(posedge clock); while (reset);
      forever begin
         segment++;
         holding = (segment % 7 == 0);
         seg_len = holding ? $urandom_range(60, 120) : $urandom_range(6, 50);
         style   = $urandom_range(0, 3);
         long_hold <= holding;
         repeat (seg_len) begin
            @(posedge clock);
            if (holding)
               rsp_ready <= 1'b0;
            else
               case (style)
                  0:       rsp_ready <= 1'b1;
                  1:       rsp_ready <= 1'($urandom_range(0, 1));
                  2:       rsp_ready <= ($urandom_range(0, 3) == 0);
                  default: rsp_ready <= ($urandom_range(0, 7) != 0);
               endcase
         end
      end
   end

   // Offer one transaction and hold it until taken
   task automatic send_item(input logic [ElapsedWidth-1:0] value);
      req_valid          <= 1'b1;
      req_elapsed_cycles <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering and wait until every predicted result has been taken
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_csr(input logic [CsrIndexWidth-1:0] index,
                            input logic [CsrDataWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_settings(input logic [3:0] which,
                                 input logic [CsrDataWidth-1:0] enable_v, compare_v,
                                 input logic [CsrDataWidth-1:0] irq_v, junk_v);
      if (which & SET_ENABLE)   write_csr(CSR_DISPLAY_ENABLE, enable_v);
      if (which & SET_COMPARE)  write_csr(CSR_LINE_COMPARE, compare_v);
      if (which & SET_IRQ)      write_csr(CSR_STATUS_IRQ_ENABLES, irq_v);
      if (which & SET_UNMAPPED) write_csr(CSR_UNMAPPED, junk_v);
      csr_valid <= 1'b0;
   endtask

   // Mostly large steps so that frames go by; lines 142 to 144 get runs of
   // full steps so vblank entry and a line advance often coincide
   function automatic logic [ElapsedWidth-1:0] pick_elapsed();
      if (sb.line_no inside {[8'd142 : 8'd144]} && $urandom_range(0, 3) != 0)
         return 8'hFF;
      case ($urandom_range(0, 9))
         0, 1, 2: return 8'hFF;
         3, 4, 5: return 8'($urandom_range(200, 254));
         6:       return 8'($urandom_range(0, 15));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_batch(input int unsigned count);
      int unsigned sent, burst, gap;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         while (burst != 0 && sent < count) begin
            send_item(pick_elapsed());
            sent++;
            burst--;
         end
         // no gaps while the consumer holds off, so the block backs up
         gap = (long_hold || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0 && sent < count) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   // Main sequence
   initial begin : stimulus
      logic [ElapsedWidth-1:0] walk [10] = '{8'd79, 8'd1, 8'd171, 8'd1, 8'd203,
                                              8'd1, 8'd0, 8'd255, 8'd255, 8'd0};
      int unsigned             phase;
      logic [3:0]              which;
      logic [CsrDataWidth-1:0] en_v, cmp_v, irq_v;

      sb = new();
      reset              <= 1'b1;
      csr_valid          <= 1'b0;
      csr_index          <= '0;
      csr_wdata          <= '0;
      req_valid          <= 1'b0;
      req_elapsed_cycles <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: first step from reset leaves vblank for OAM scan on line 0
      send_item(8'd0);
      settle();
      // all status sources on (upper data bits must be dropped), compare line 1;
      // walk every mode boundary, then skip modes with full steps
      apply_settings(SET_COMPARE | SET_IRQ, '0, 8'd1, 8'hFF, '0);
      foreach (walk[i])
         send_item(walk[i]);
      settle();
      // display off with a wide write: counter, line and mode cleared
      apply_settings(SET_ENABLE | SET_COMPARE | SET_IRQ, 8'hFE, 8'hFF, 8'h00, '0);
      send_item(8'd255);
      send_item(8'd0);
      settle();
      // back on; a write beyond the register list must change nothing
      apply_settings(SET_ENABLE | SET_UNMAPPED, 8'h01, '0, '0, 8'hFF);
      send_item(8'd255);
      send_item(8'd255);
      send_item(8'd128);
      settle();

      // Random phases, each with fresh register values written while idle
      for (phase = 0; phase < PHASES; phase++) begin
         which = SET_COMPARE | SET_IRQ;
         en_v  = 8'($urandom_range(0, 255)) | 8'h01;
         if (phase == OFF_PHASE) begin
            en_v  = en_v & 8'hFE;
            which = which | SET_ENABLE;
         end else if (phase == OFF_PHASE + 1 || $urandom_range(0, 3) == 0) begin
            which = which | SET_ENABLE;
         end
         if ($urandom_range(0, 2) == 0)
            which = which | SET_UNMAPPED;
         case ($urandom_range(0, 5))
            0:       cmp_v = '0;
            1:       cmp_v = LAST_LINE;
            2:       cmp_v = 8'hFF;
            default: cmp_v = 8'($urandom_range(0, 153));
         endcase
         irq_v = 8'($urandom_range(0, 255));
         if (phase == 0)
            irq_v = irq_v | 8'h0F;
         if (phase == 1)
            irq_v = irq_v & 8'hF0;
         apply_settings(which, en_v, cmp_v, irq_v, 8'($urandom_range(0, 255)));
         send_batch(phase == OFF_PHASE ? 24 : 128);
         settle();
      end

      // tail: nothing more may come out
      repeat (8) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d expected results never arrived", sb.pending()));

      $display("Checked %0d results after %0d register writes, %0d frame wraps, %0d %s",
               sb.checked, sb.reg_writes, sb.frames, sb.vblanks, "vblank entries.");
      $display("Saw %0d status interrupts, %0d line renders, %0d line-compare matches.",
               sb.status_irqs, sb.renders, sb.compare_hits);
      if (sb.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/lsmt_pkg.sv
design/lcd_scanline_mode_timing.sv
dv/lcd_scanline_mode_timing_tb.sv
